// ----- rtl/lcst_pkg.sv -----
// ----------------------------------------------------------------------------
// lcst_pkg
// Shared types and fixed constants of the lamp colour smoothing tuner.
// ----------------------------------------------------------------------------
package lcst_pkg;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_SCHED = 2'd1,
      CMD_ENC   = 2'd2,
      CMD_LOAD  = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_EASE_GO,
      ST_EASE_WAIT,
      ST_COMP,
      ST_CONV_PREP,
      ST_CONV_SAT,
      ST_CONV_HUE,
      ST_ENC,
      ST_LOAD,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      SEL_LEVEL,
      SEL_HUE,
      SEL_SAT,
      SEL_GOAL
   } ease_sel_type;

   localparam logic [7:0] HUE_OFF_RED   = 8'd0;
   localparam logic [7:0] HUE_OFF_GREEN = 8'd42;
   localparam logic [7:0] HUE_OFF_BLUE  = 8'd85;
   localparam logic [7:0] HUE_GAIN      = 8'd42;
   localparam logic [7:0] SAT_GAIN      = 8'd255;

   localparam logic [7:0] RESET_RED     = 8'd255;
   localparam logic [7:0] RESET_GREEN   = 8'd175;
   localparam logic [7:0] RESET_BLUE    = 8'd90;
   localparam logic [7:0] RESET_LEVEL   = 8'd200;
   localparam logic [7:0] RESET_HUE     = 8'd32;
   localparam logic [7:0] RESET_SAT     = 8'd200;

endpackage

// ----- rtl/lcst_mul.sv -----
// ----------------------------------------------------------------------------
// lcst_mul
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module lcst_mul
   import lcst_pkg::*;
#(
   parameter int AW = 24,
   parameter int BW = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [AW-1:0]    a,
   input  logic [BW-1:0]    b,
   output logic [AW+BW-1:0] prod,
   output logic             done
);

   localparam int CW = $clog2(BW + 1);

   logic [AW-1:0]    a_ff, a_in;
   logic [AW+BW-1:0] acc_ff, acc_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [AW:0]      sum;

   always_comb begin
      a_in    = a_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sum     = {1'b0, acc_ff[AW+BW-1:BW]} + (acc_ff[0] ? {1'b0, a_ff} : '0);
      if (start) begin
         a_in    = a;
         acc_in  = {{AW{1'b0}}, b};
         cnt_in  = CW'(BW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {sum, acc_ff[BW-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      acc_ff <= acc_in;
   end

   assign prod = acc_ff;
   assign done = done_ff;

endmodule

// ----- rtl/lcst_div.sv -----
// ----------------------------------------------------------------------------
// lcst_div
// Restoring divider, one quotient bit per cycle; quotient must fit QB bits.
// ----------------------------------------------------------------------------
module lcst_div
   import lcst_pkg::*;
#(
   parameter int NW = 33,
   parameter int DW = 9,
   parameter int QB = 24
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QB-1:0] quo,
   output logic          done
);

   localparam int CW = $clog2(QB + 1);

   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [QB-1:0] nsh_ff, nsh_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          ge;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      nsh_in  = nsh_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, nsh_ff[QB-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = (trial >= {1'b0, den_ff});
      if (start) begin
         rem_in  = DW'(num[NW-1:QB]);
         den_in  = den;
         nsh_in  = num[QB-1:0];
         cnt_in  = CW'(QB);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
         nsh_in = {nsh_ff[QB-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      nsh_ff <= nsh_in;
   end

   assign quo  = nsh_ff;
   assign done = done_ff;

endmodule

// ----- rtl/led_color_smoothing_tuner.sv -----
// ----------------------------------------------------------------------------
// led_color_smoothing_tuner
// Smoothed brightness, hue and saturation of a lamp with encoder, schedule
// and default controls; fixed point with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// One request at a time. A control tick runs one bit-serial multiply per
// eased value (one, or three in manual colour mode). A schedule tick, when
// its schedule is valid, runs RGB easing, a setup state and the
// hue/saturation conversion (two serial divisions, skipped for a grey
// colour) while the colour follows the schedule, then one more serial
// multiply for the brightness target while the brightness does. Load
// defaults runs the setup state and the two divisions (skipped for a grey
// colour). A new request is accepted in the cycle after its predecessor's
// response is loaded, while that response may still wait to be taken; a
// response that is held back stalls the next one.
// ----------------------------------------------------------------------------
module led_color_smoothing_tuner
   import lcst_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_cmd,
   input  logic signed [7:0] req_bright_knob_delta,
   input  logic signed [7:0] req_color_knob_delta,
   input  logic              req_sat_select,
   input  logic              req_schedule_valid,
   input  logic [7:0]        req_level_in,
   input  logic [7:0]        req_red_in,
   input  logic [7:0]        req_green_in,
   input  logic [7:0]        req_blue_in,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_level_out,
   output logic [7:0]        rsp_hue_out,
   output logic [7:0]        rsp_sat_out,
   output logic [7:0]        rsp_red_out,
   output logic [7:0]        rsp_green_out,
   output logic [7:0]        rsp_blue_out,
   output logic              rsp_level_manual,
   output logic              rsp_color_manual
);

   localparam int F   = FRAC_BITS;
   localparam int QW  = 8 + F;
   localparam int NW  = F + 17;
   localparam int DW  = 9;
   localparam int PW  = F + 11;

   localparam logic [63:0] QONE64   = 64'd1 << F;
   localparam logic [63:0] RTICK64  = (64'd11 * QONE64 * 64'd2 + 64'd200) / 64'd400;
   localparam logic [63:0] RSCHED64 = (64'd3 * QONE64 * 64'd2 + 64'd250) / 64'd500;
   localparam logic [63:0] SNAP64   = (QONE64 * 64'd2 + 64'd25) / 64'd50;
   localparam logic [63:0] SLVL64   = (64'd7 * QONE64 * 64'd2 + 64'd2) / 64'd4;
   localparam logic [63:0] SHUE64   = (64'd6 * QONE64 * 64'd2 + 64'd5) / 64'd10;
   localparam logic [63:0] SSAT64   = 64'd3 * QONE64;
   localparam logic [63:0] QMAX64   = 64'd255 * QONE64;
   localparam logic [63:0] QHALF64  = QONE64 >> 1;

   localparam logic [F-1:0]  RATE_TICK  = RTICK64[F-1:0];
   localparam logic [F-1:0]  RATE_SCHED = RSCHED64[F-1:0];
   localparam logic [QW-1:0] SNAP_Q     = SNAP64[QW-1:0];
   localparam logic [QW-1:0] STEP_LVL   = SLVL64[QW-1:0];
   localparam logic [QW-1:0] STEP_HUE   = SHUE64[QW-1:0];
   localparam logic [QW-1:0] STEP_SAT   = SSAT64[QW-1:0];
   localparam logic [QW-1:0] QMAX_Q     = QMAX64[QW-1:0];
   localparam logic [QW-1:0] QHALF_Q    = QHALF64[QW-1:0];

   function automatic logic [QW-1:0] clampq(input logic signed [QW+2:0] v);
      logic [QW-1:0] r;
      if (v < 0) r = '0;
      else if (v > $signed({3'b000, QMAX_Q})) r = QMAX_Q;
      else r = v[QW-1:0];
      return r;
   endfunction

   state_type    state_ff, state_in;
   ease_sel_type esel_ff, esel_in;
   logic [1:0]   idx_ff, idx_in;

   cmd_type     cmd_ff, cmd_in;
   logic [7:0]  bd_ff, bd_in, cd_ff, cd_in;
   logic        satsel_ff, satsel_in, sv_ff, sv_in;
   logic [7:0]  lvl_ff, lvl_in, rin_ff, rin_in, gin_ff, gin_in, bin_ff, bin_in;

   logic [QW-1:0] level_now_ff, level_now_in, level_goal_ff, level_goal_in;
   logic [QW-1:0] hue_now_ff, hue_now_in, hue_goal_ff, hue_goal_in;
   logic [QW-1:0] sat_now_ff, sat_now_in, sat_goal_ff, sat_goal_in;
   logic [7:0]    red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic          lfs_ff, lfs_in, cfs_ff, cfs_in;

   logic [7:0]    dl_ff, dl_in, mag_ff, mag_in, off_ff, off_in;
   logic          neg_ff, neg_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    ol_ff, ol_in, oh_ff, oh_in, os_ff, os_in;
   logic [7:0]    or_ff, or_in, og_ff, og_in, ob_ff, ob_in;
   logic          olm_ff, olm_in, ocm_ff, ocm_in;

   logic              mul_start, mul_done;
   logic [QW-1:0]     mul_a;
   logic [F-1:0]      mul_b;
   logic [QW+F-1:0]   mul_prod;
   logic              div_start, div_done;
   logic [NW-1:0]     div_num;
   logic [DW-1:0]     div_den;
   logic [QW-1:0]     div_quo;

   // ease datapath
   logic [QW-1:0]        e_now, e_goal, hue_u;
   logic signed [QW+1:0] e_d;
   logic [QW+1:0]        e_abs;
   logic [QW-1:0]        e_mag, e_step, e_fin;
   logic [QW+F:0]        e_rsum;
   logic signed [QW+2:0] e_res;
   logic                 e_snap;

   // colour conversion
   logic [7:0]  mx, mn, cv_dl, cv_mag, cv_off;
   logic signed [8:0] cv_num;
   logic [15:0] dl255, mag42;
   logic [NW-1:0] sat_num, hue_num;
   logic [QW-1:0] hue_hv, hue_sq;

   // schedule colour easing
   logic [7:0]            c_cur, c_tgt, c_new;
   logic signed [8:0]     c_d;
   logic signed [PW-1:0]  c_p;

   // encoder
   logic signed [QW+2:0] bd_ext, cd_ext, lg_sum, sg_sum, hg_sum;
   logic [QW-1:0]        rnd_l, rnd_h, rnd_s;
   logic                 can_load;

   lcst_mul #(.AW(QW), .BW(F)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (mul_prod),
      .done  (mul_done)
   );

   lcst_div #(.NW(NW), .DW(DW), .QB(QW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (div_quo),
      .done  (div_done)
   );

   // ease difference, step and result
   always_comb begin
      case (esel_ff)
         SEL_LEVEL: begin e_now = level_now_ff;  e_goal = level_goal_ff; end
         SEL_HUE:   begin e_now = hue_now_ff;    e_goal = hue_goal_ff;   end
         SEL_SAT:   begin e_now = sat_now_ff;    e_goal = sat_goal_ff;   end
         default:   begin e_now = level_goal_ff; e_goal = {lvl_ff, {F{1'b0}}}; end
      endcase
      hue_u = e_goal - e_now;
      if (esel_ff == SEL_HUE) begin
         if (hue_u[QW-1] && (|hue_u[QW-2:0])) e_d = $signed({2'b11, hue_u});
         else e_d = $signed({2'b00, hue_u});
      end else begin
         e_d = $signed({2'b00, e_goal}) - $signed({2'b00, e_now});
      end
      e_abs  = e_d[QW+1] ? (~e_d + 1'b1) : e_d;
      e_mag  = e_abs[QW-1:0];
      e_snap = (e_mag < SNAP_Q);
      e_rsum = {1'b0, mul_prod} + {{(F+1){1'b0}}, QHALF_Q};
      e_step = e_rsum[QW+F-1:F];
      if (e_step == '0) e_step = QW'(1);
      if (e_snap) e_res = $signed({3'b000, e_goal});
      else if (e_d[QW+1]) e_res = $signed({3'b000, e_now}) - $signed({3'b000, e_step});
      else e_res = $signed({3'b000, e_now}) + $signed({3'b000, e_step});
      e_fin = (esel_ff == SEL_HUE) ? e_res[QW-1:0] : clampq(e_res);
   end

   // colour conversion operands
   always_comb begin
      mx = red_ff;
      mn = red_ff;
      if (green_ff > mx) mx = green_ff;
      if (blue_ff > mx) mx = blue_ff;
      if (green_ff < mn) mn = green_ff;
      if (blue_ff < mn) mn = blue_ff;
      cv_dl = mx - mn;
      if (mx == red_ff) begin
         cv_num = $signed({1'b0, green_ff}) - $signed({1'b0, blue_ff});
         cv_off = HUE_OFF_RED;
      end else if (mx == green_ff) begin
         cv_num = $signed({1'b0, blue_ff}) - $signed({1'b0, red_ff});
         cv_off = HUE_OFF_GREEN;
      end else begin
         cv_num = $signed({1'b0, red_ff}) - $signed({1'b0, green_ff});
         cv_off = HUE_OFF_BLUE;
      end
      cv_mag  = cv_num[8] ? 8'(-cv_num) : cv_num[7:0];
      dl255   = {8'd0, cv_dl} * {8'd0, SAT_GAIN};
      mag42   = {8'd0, mag_ff} * {8'd0, HUE_GAIN};
      sat_num = {dl255, {(F+1){1'b0}}} | {{(NW-8){1'b0}}, mx};
      hue_num = {mag42, {(F+1){1'b0}}} | {{(NW-8){1'b0}}, dl_ff};
      hue_sq  = neg_ff ? (~div_quo + 1'b1) : div_quo;
      hue_hv  = {off_ff, {F{1'b0}}} + hue_sq;
   end

   // schedule colour step
   always_comb begin
      case (idx_ff)
         2'd0:    begin c_cur = red_ff;   c_tgt = rin_ff; end
         2'd1:    begin c_cur = green_ff; c_tgt = gin_ff; end
         default: begin c_cur = blue_ff;  c_tgt = bin_ff; end
      endcase
      c_d   = $signed({1'b0, c_tgt}) - $signed({1'b0, c_cur});
      c_p   = $signed({{(F+2){c_d[8]}}, c_d}) * $signed({11'd0, RATE_SCHED})
              + $signed({{(PW-QW){1'b0}}, QHALF_Q});
      c_new = c_cur + c_p[F+7:F];
   end

   // encoder targets, response rounding and response load condition
   always_comb begin
      bd_ext = $signed({{(QW-5){bd_ff[7]}}, bd_ff});
      cd_ext = $signed({{(QW-5){cd_ff[7]}}, cd_ff});
      lg_sum = $signed({3'b000, level_goal_ff}) + bd_ext * $signed({3'b000, STEP_LVL});
      sg_sum = $signed({3'b000, sat_goal_ff}) + cd_ext * $signed({3'b000, STEP_SAT});
      hg_sum = $signed({3'b000, hue_goal_ff}) + cd_ext * $signed({3'b000, STEP_HUE});
      rnd_l  = level_now_ff + QHALF_Q;
      rnd_h  = hue_now_ff + QHALF_Q;
      rnd_s  = sat_now_ff + QHALF_Q;
      can_load = !rsp_valid_ff || rsp_ready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:
            if (req_valid) state_in = ST_DISPATCH;
         ST_DISPATCH:
            case (cmd_ff)
               CMD_TICK: state_in = ST_EASE_GO;
               CMD_SCHED:
                  if (!sv_ff) state_in = ST_FINISH;
                  else if (cfs_ff) state_in = ST_COMP;
                  else if (lfs_ff) state_in = ST_EASE_GO;
                  else state_in = ST_FINISH;
               CMD_ENC: state_in = ST_ENC;
               default: state_in = ST_LOAD;
            endcase
         ST_EASE_GO:
            state_in = ST_EASE_WAIT;
         ST_EASE_WAIT:
            if (mul_done) begin
               if ((esel_ff == SEL_LEVEL && !cfs_ff) || esel_ff == SEL_HUE)
                  state_in = ST_EASE_GO;
               else
                  state_in = ST_FINISH;
            end
         ST_COMP:
            if (idx_ff == 2'd2) state_in = ST_CONV_PREP;
         ST_CONV_PREP:
            if (cv_dl != '0) state_in = ST_CONV_SAT;
            else if (cmd_ff == CMD_SCHED && lfs_ff) state_in = ST_EASE_GO;
            else state_in = ST_FINISH;
         ST_CONV_SAT:
            if (div_done) state_in = ST_CONV_HUE;
         ST_CONV_HUE:
            if (div_done) begin
               if (cmd_ff == CMD_SCHED && lfs_ff) state_in = ST_EASE_GO;
               else state_in = ST_FINISH;
            end
         ST_ENC:
            state_in = ST_FINISH;
         ST_LOAD:
            state_in = ST_CONV_PREP;
         ST_FINISH:
            if (can_load) state_in = ST_IDLE;
         default:
            state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      mul_start = (state_ff == ST_EASE_GO);
      mul_a     = e_mag;
      mul_b     = (esel_ff == SEL_GOAL) ? RATE_SCHED : RATE_TICK;
      div_start = (state_ff == ST_CONV_PREP && cv_dl != '0) ||
                  (state_ff == ST_CONV_SAT && div_done);
      if (state_ff == ST_CONV_PREP) begin
         div_num = sat_num;
         div_den = {mx, 1'b0};
      end else begin
         div_num = hue_num;
         div_den = {dl_ff, 1'b0};
      end
   end

   // datapath next values
   always_comb begin
      esel_in = esel_ff;      idx_in = idx_ff;
      cmd_in = cmd_ff;        bd_in = bd_ff;        cd_in = cd_ff;
      satsel_in = satsel_ff;  sv_in = sv_ff;        lvl_in = lvl_ff;
      rin_in = rin_ff;        gin_in = gin_ff;      bin_in = bin_ff;
      level_now_in = level_now_ff;  level_goal_in = level_goal_ff;
      hue_now_in = hue_now_ff;      hue_goal_in = hue_goal_ff;
      sat_now_in = sat_now_ff;      sat_goal_in = sat_goal_ff;
      red_in = red_ff;  green_in = green_ff;  blue_in = blue_ff;
      lfs_in = lfs_ff;  cfs_in = cfs_ff;
      dl_in = dl_ff;    mag_in = mag_ff;  off_in = off_ff;  neg_in = neg_ff;
      ol_in = ol_ff;    oh_in = oh_ff;    os_in = os_ff;
      or_in = or_ff;    og_in = og_ff;    ob_in = ob_ff;
      olm_in = olm_ff;  ocm_in = ocm_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE:
            if (req_valid) begin
               cmd_in    = cmd_type'(req_cmd);
               bd_in     = req_bright_knob_delta;
               cd_in     = req_color_knob_delta;
               satsel_in = req_sat_select;
               sv_in     = req_schedule_valid;
               lvl_in    = req_level_in;
               rin_in    = req_red_in;
               gin_in    = req_green_in;
               bin_in    = req_blue_in;
            end
         ST_DISPATCH: begin
            idx_in  = 2'd0;
            esel_in = (cmd_ff == CMD_TICK) ? SEL_LEVEL : SEL_GOAL;
         end
         ST_EASE_WAIT:
            if (mul_done) begin
               case (esel_ff)
                  SEL_LEVEL: begin level_now_in = e_fin; esel_in = SEL_HUE; end
                  SEL_HUE:   begin hue_now_in = e_fin;   esel_in = SEL_SAT; end
                  SEL_SAT:   sat_now_in = e_fin;
                  default:   level_goal_in = e_fin;
               endcase
            end
         ST_COMP: begin
            case (idx_ff)
               2'd0:    red_in = c_new;
               2'd1:    green_in = c_new;
               default: blue_in = c_new;
            endcase
            idx_in = idx_ff + 1'b1;
         end
         ST_CONV_PREP: begin
            esel_in = SEL_GOAL;
            dl_in   = cv_dl;
            mag_in  = cv_mag;
            off_in  = cv_off;
            neg_in  = cv_num[8];
            if (cv_dl == '0) begin
               hue_now_in = '0;  hue_goal_in = '0;
               sat_now_in = '0;  sat_goal_in = '0;
            end
         end
         ST_CONV_SAT:
            if (div_done) begin
               sat_now_in  = div_quo;
               sat_goal_in = div_quo;
            end
         ST_CONV_HUE:
            if (div_done) begin
               hue_now_in  = hue_hv;
               hue_goal_in = hue_hv;
            end
         ST_ENC: begin
            if (bd_ff != '0) begin
               lfs_in        = 1'b0;
               level_goal_in = clampq(lg_sum);
            end
            if (cd_ff != '0) begin
               cfs_in = 1'b0;
               if (satsel_ff) sat_goal_in = clampq(sg_sum);
               else hue_goal_in = hg_sum[QW-1:0];
            end
         end
         ST_LOAD: begin
            level_now_in  = {lvl_ff, {F{1'b0}}};
            level_goal_in = {lvl_ff, {F{1'b0}}};
            red_in   = rin_ff;
            green_in = gin_ff;
            blue_in  = bin_ff;
            lfs_in   = 1'b1;
            cfs_in   = 1'b1;
         end
         ST_FINISH:
            if (can_load) begin
               rsp_valid_in = 1'b1;
               ol_in  = rnd_l[QW-1:F];
               oh_in  = rnd_h[QW-1:F];
               os_in  = rnd_s[QW-1:F];
               or_in  = red_ff;
               og_in  = green_ff;
               ob_in  = blue_ff;
               olm_in = !lfs_ff;
               ocm_in = !cfs_ff;
            end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         esel_ff       <= SEL_LEVEL;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         level_now_ff  <= {RESET_LEVEL, {F{1'b0}}};
         level_goal_ff <= {RESET_LEVEL, {F{1'b0}}};
         hue_now_ff    <= {RESET_HUE, {F{1'b0}}};
         hue_goal_ff   <= {RESET_HUE, {F{1'b0}}};
         sat_now_ff    <= {RESET_SAT, {F{1'b0}}};
         sat_goal_ff   <= {RESET_SAT, {F{1'b0}}};
         red_ff        <= RESET_RED;
         green_ff      <= RESET_GREEN;
         blue_ff       <= RESET_BLUE;
         lfs_ff        <= 1'b1;
         cfs_ff        <= 1'b1;
      end else begin
         state_ff      <= state_in;
         esel_ff       <= esel_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
         level_now_ff  <= level_now_in;
         level_goal_ff <= level_goal_in;
         hue_now_ff    <= hue_now_in;
         hue_goal_ff   <= hue_goal_in;
         sat_now_ff    <= sat_now_in;
         sat_goal_ff   <= sat_goal_in;
         red_ff        <= red_in;
         green_ff      <= green_in;
         blue_ff       <= blue_in;
         lfs_ff        <= lfs_in;
         cfs_ff        <= cfs_in;
      end
      cmd_ff    <= cmd_in;
      bd_ff     <= bd_in;
      cd_ff     <= cd_in;
      satsel_ff <= satsel_in;
      sv_ff     <= sv_in;
      lvl_ff    <= lvl_in;
      rin_ff    <= rin_in;
      gin_ff    <= gin_in;
      bin_ff    <= bin_in;
      dl_ff     <= dl_in;
      mag_ff    <= mag_in;
      off_ff    <= off_in;
      neg_ff    <= neg_in;
      ol_ff     <= ol_in;
      oh_ff     <= oh_in;
      os_ff     <= os_in;
      or_ff     <= or_in;
      og_ff     <= og_in;
      ob_ff     <= ob_in;
      olm_ff    <= olm_in;
      ocm_ff    <= ocm_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_level_out    = ol_ff;
   assign rsp_hue_out      = oh_ff;
   assign rsp_sat_out      = os_ff;
   assign rsp_red_out      = or_ff;
   assign rsp_green_out    = og_ff;
   assign rsp_blue_out     = ob_ff;
   assign rsp_level_manual = olm_ff;
   assign rsp_color_manual = ocm_ff;

endmodule
